[rtl/punf_pkg.sv]
// shared types and constants for the png row unfilter
`default_nettype none
package punf_pkg;

  localparam int NUM_LANES = 4;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  typedef logic [7:0] lane_t;
  typedef logic [1:0] op_t;

  localparam op_t OP_SUB   = 2'd0;
  localparam op_t OP_AVG   = 2'd1;
  localparam op_t OP_PAETH = 2'd2;

  localparam logic [2:0] BPP_RGB   = 3'd3;
  localparam logic [2:0] BPP_RESET = 3'd4;

  // word index of the register, taken from paddr[2]
  localparam logic REG_BPP = 1'b0;

  typedef struct packed {
    logic       three;
  } cfg_t;

endpackage
`default_nettype wire

[rtl/punf_in_if.sv]
// input channel: filtered pixel beat with its above pixel
`default_nettype none
interface punf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic        row_start;
  logic [7:0]  filt_byte0;
  logic [7:0]  filt_byte1;
  logic [7:0]  filt_byte2;
  logic [7:0]  filt_byte3;
  logic [7:0]  above_byte0;
  logic [7:0]  above_byte1;
  logic [7:0]  above_byte2;
  logic [7:0]  above_byte3;

  modport source (
    output valid, op, row_start, filt_byte0, filt_byte1, filt_byte2, filt_byte3,
    output above_byte0, above_byte1, above_byte2, above_byte3,
    input  ready
  );
  modport sink (
    input  valid, op, row_start, filt_byte0, filt_byte1, filt_byte2, filt_byte3,
    input  above_byte0, above_byte1, above_byte2, above_byte3,
    output ready
  );
endinterface
`default_nettype wire

[rtl/punf_out_if.sv]
// result channel: reconstructed pixel beat
`default_nettype none
interface punf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte0;
  logic [7:0]  out_byte1;
  logic [7:0]  out_byte2;
  logic [7:0]  out_byte3;

  modport source (
    output valid, out_byte0, out_byte1, out_byte2, out_byte3,
    input  ready
  );
  modport sink (
    input  valid, out_byte0, out_byte1, out_byte2, out_byte3,
    output ready
  );
endinterface
`default_nettype wire

[rtl/punf_cfg.sv]
// apb register bank holding bytes_per_pixel
`default_nettype none
module punf_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [punf_pkg::CFG_AW-1:0] paddr,
  input  wire logic [punf_pkg::CFG_DW-1:0] pwdata,
  output logic      [punf_pkg::CFG_DW-1:0] prdata,
  output logic                             pready,
  output punf_pkg::cfg_t                   cfg
);

  logic [2:0] bpp_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == punf_pkg::REG_BPP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r <= punf_pkg::BPP_RESET;
    end else if (wr_en) begin
      bpp_r <= pwdata[2:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == punf_pkg::REG_BPP) begin
      prdata = {{(punf_pkg::CFG_DW-3){1'b0}}, bpp_r};
    end
  end

  // anything other than three acts as four
  assign cfg.three = (bpp_r == punf_pkg::BPP_RGB);

endmodule
`default_nettype wire

[rtl/punf_lane.sv]
// one byte lane of the predictor and adder
`default_nettype none
module punf_lane (
  input  wire logic            active,
  input  wire logic            row_start,
  input  wire punf_pkg::op_t   op,
  input  wire punf_pkg::lane_t filt,
  input  wire punf_pkg::lane_t above,
  input  wire punf_pkg::lane_t left,
  input  wire punf_pkg::lane_t upleft,
  output punf_pkg::lane_t      recon,
  output punf_pkg::lane_t      above_keep
);

  punf_pkg::lane_t a;
  punf_pkg::lane_t c;
  punf_pkg::lane_t pred;
  logic        [8:0] avg_sum;
  logic signed [9:0] d_bc;
  logic signed [9:0] d_ac;
  logic signed [9:0] d_sum;
  logic signed [9:0] pa;
  logic signed [9:0] pb;
  logic signed [9:0] pc;
  punf_pkg::lane_t paeth;

  assign a = row_start ? 8'd0 : left;
  assign c = row_start ? 8'd0 : upleft;

  assign avg_sum = {1'b0, a} + {1'b0, above};

  assign d_bc  = $signed({2'b00, above}) - $signed({2'b00, c});
  assign d_ac  = $signed({2'b00, a}) - $signed({2'b00, c});
  assign d_sum = d_bc + d_ac;
  assign pa    = d_bc[9]  ? -d_bc  : d_bc;
  assign pb    = d_ac[9]  ? -d_ac  : d_ac;
  assign pc    = d_sum[9] ? -d_sum : d_sum;

  // ties go to left, then to above
  always_comb begin
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = above;
    end else begin
      paeth = c;
    end
  end

  always_comb begin
    case (op)
      punf_pkg::OP_SUB:   pred = a;
      punf_pkg::OP_AVG:   pred = avg_sum[8:1];
      punf_pkg::OP_PAETH: pred = paeth;
      default:            pred = 8'd0;
    endcase
  end

  assign recon      = active ? (filt + pred) : 8'd0;
  assign above_keep = active ? above : 8'd0;

endmodule
`default_nettype wire

[rtl/png_row_unfilter.sv]
// top level of the png row unfilter: input register, lane datapath, result register
//
//   channel | role   | beat
//   in_ch   | sink   | op, row_start, filt_byte0..3, above_byte0..3
//   out_ch  | source | out_byte0..3
//   cfg_*   | apb    | bytes_per_pixel at byte address 0
//
// one pixel per clock sustained while the result is accepted; a beat is captured in
// the input register and then moves on to the result register.
// the left and upper-left pixels update as a beat moves to the result register,
// which is the feedback loop that sets the rate.
// synchronous active-low reset clears both context pixels and the valid flags.
// a stalled result holds while the input register still takes one more beat.
`default_nettype none
module png_row_unfilter (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  punf_in_if.sink                          in_ch,
  punf_out_if.source                       out_ch,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [punf_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [punf_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [punf_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                             cfg_pready
);

  localparam int NL = punf_pkg::NUM_LANES;

  punf_pkg::cfg_t cfg;

  logic                  in_valid_r;
  punf_pkg::op_t         in_op_r;
  logic                  in_start_r;
  logic [NL*8-1:0]       in_filt_r;
  logic [NL*8-1:0]       in_above_r;
  logic                  out_valid_r;
  logic [NL*8-1:0]       out_data_r;
  logic [NL*8-1:0]       left_r;
  logic [NL*8-1:0]       upleft_r;
  logic [NL*8-1:0]       recon;
  logic [NL*8-1:0]       above_keep;
  logic                  move;
  logic                  take;

  punf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign move        = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || move;
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (take) begin
      in_valid_r <= 1'b1;
    end else if (move) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_op_r    <= in_ch.op;
      in_start_r <= in_ch.row_start;
      in_filt_r  <= {in_ch.filt_byte3, in_ch.filt_byte2, in_ch.filt_byte1,
                     in_ch.filt_byte0};
      in_above_r <= {in_ch.above_byte3, in_ch.above_byte2, in_ch.above_byte1,
                     in_ch.above_byte0};
    end
  end

  for (genvar i = 0; i < NL; i++) begin : g_lane
    punf_lane u_lane (
      .active     ((i < NL - 1) || !cfg.three),
      .row_start  (in_start_r),
      .op         (in_op_r),
      .filt       (in_filt_r[i*8 +: 8]),
      .above      (in_above_r[i*8 +: 8]),
      .left       (left_r[i*8 +: 8]),
      .upleft     (upleft_r[i*8 +: 8]),
      .recon      (recon[i*8 +: 8]),
      .above_keep (above_keep[i*8 +: 8])
    );
  end

  // context follows the beat into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      upleft_r <= '0;
    end else if (move) begin
      left_r   <= recon;
      upleft_r <= above_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data_r <= recon;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte0 = out_data_r[7:0];
  assign out_ch.out_byte1 = out_data_r[15:8];
  assign out_ch.out_byte2 = out_data_r[23:16];
  assign out_ch.out_byte3 = out_data_r[31:24];

  a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_valid_r)
    else $error("beat moved but result register not valid");

  a_rgb_lane3_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (move && cfg.three) |=> (out_data_r[31:24] == 8'd0 && left_r[31:24] == 8'd0 &&
                             upleft_r[31:24] == 8'd0))
    else $error("lane 3 not cleared at three bytes per pixel");

  a_upleft_tracks_above: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> (upleft_r[7:0] == $past(in_above_r[7:0])))
    else $error("upper-left context does not follow the above pixel");

  a_left_is_result: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> (left_r == out_data_r))
    else $error("left context differs from the delivered result");

  a_empty_is_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_ch.ready)
    else $error("empty input register refuses a beat");

endmodule
`default_nettype wire
